/* rtl/core/vfpd_pkg.sv */
// vfpd_pkg: shared types and constants for the valve frequency pd controller
// used by valve_frequency_pd_with_yaw_split and its checker
// no dependencies
`timescale 1ns / 1ps

package vfpd_pkg;

    // event kinds on the input tuser
    localparam logic [2:0] KIND_RISE   = 3'd0;
    localparam logic [2:0] KIND_FALL   = 3'd1;
    localparam logic [2:0] KIND_UPDATE = 3'd2;
    localparam logic [2:0] KIND_START  = 3'd3;
    localparam logic [2:0] KIND_STOP   = 3'd4;

    // config register indexes
    localparam logic [1:0] REG_PROP = 2'd0;
    localparam logic [1:0] REG_DERIV = 2'd1;
    localparam logic [1:0] REG_YAW = 2'd2;
    localparam logic [1:0] REG_FF = 2'd3;

    localparam logic [15:0] FF_GAIN_RESET = 16'd53687;
    localparam logic [15:0] FULL_LEVEL = 16'd32768;
    localparam logic [15:0] LOW_LEVEL = 16'd1638;

    // 1e9 mHz*us, fits in 30 bits
    localparam int DIV_QW = 30;
    localparam logic [DIV_QW-1:0] MHZ_PER_US = 30'd1000000000;

    // shared multiplier: 36 x 36 signed, one operand bit per cycle
    localparam int MUL_W = 36;
    localparam int PROD_W = 2 * MUL_W;
    localparam logic [5:0] MUL_LAST = 6'(MUL_W - 1);

    localparam int IN_W = 80;
    localparam int OUT_W = 136;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_FF,
        S_TO,
        S_TOCHK,
        S_PM,
        S_DM,
        S_SUM,
        S_YW,
        S_SP,
        S_CLAMP,
        S_DONE
    } t_state;

endpackage

/* rtl/core/valve_frequency_pd_with_yaw_split.sv */
// valve_frequency_pd_with_yaw_split: hall timing, frequency pd loop and yaw split
// depends on vfpd_pkg; one shared serial multiplier and one restoring divider
`timescale 1ns / 1ps

// usage
// - input words on s_t*: tuser carries the event kind (rise, fall, update,
//   start, stop), tdata carries time stamp, target frequency, yaw and thrust
// - every input word gives exactly one output word on m_t* with the drive
//   levels, side, run and timeout flags, measured frequency and half periods
// - gains are to be written on the cfg channel while the block is idle; the
//   block does not enforce this, and the cfg channel is always ready
// - s_tready is high only while the sequencer waits for a word
// - per accepted word: start, stop, unused kinds and updates while stopped
//   go straight to the output; hall edges run a 30-step restoring divide of
//   1e9 by the period, skipped with a zero period; updates run feedforward,
//   yaw and split products (feedforward), the timeout product and check
//   (timeout), p, d, yaw and split products (zero target) or the timeout
//   check, p and d products, yaw product and split product, each product
//   being a load step and 36 add/shift steps of the shared multiplier
// - the sequencer handles one word at a time, no new word before it is done
// - the result sits in an output register; a stalled receiver holds the
//   next word in the final state until the register frees up
// - reset (synchronous, active low) clears loop state and gains to their
//   power-up values and empties the output register

module valve_frequency_pd_with_yaw_split
    import vfpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // config write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [23:0]       i_cfg_data,
    // input words
    input  logic              s_tvalid,
    output logic              s_tready,
    // now_us[31:0], target_freq_mhz[47:32], yaw_cmd[63:48], thrust_cmd[79:64]
    input  logic [IN_W-1:0]   s_tdata,
    // kind[2:0]
    input  logic [2:0]        s_tuser,
    // result words
    output logic              m_tvalid,
    input  logic              m_tready,
    // pump_duty[15:0], valve_duty[31:16], side[32], is_running[33],
    // timed_out[34], measured_freq_mhz[66:35], first_half_us[98:67],
    // second_half_us[130:99], zero pad[135:131]
    output logic [OUT_W-1:0]  m_tdata
);

    t_state r_state, n_state;

    // gains
    logic [23:0] r_prop, r_deriv;
    logic [15:0] r_ysg, r_ffg;

    // latched event
    logic [31:0] r_now;
    logic [15:0] r_target, r_yaw;

    // loop state
    logic               r_side, r_run, r_tout, r_pd;
    logic [31:0]        r_half1, r_half2, r_last, r_freq;
    logic signed [31:0] r_prev, r_level;
    logic [15:0]        r_pump, r_valve;
    logic signed [33:0] r_err;
    logic signed [PROD_W-1:0] r_acc;

    // shared multiplier
    logic                     r_busy;
    logic signed [PROD_W-1:0] r_mcand, r_prod;
    logic [MUL_W-1:0]         r_mplier;
    logic [5:0]               r_mcnt;

    // divider
    logic [32:0]       r_dsum, r_rem;
    logic [DIV_QW-1:0] r_quo;
    logic [4:0]        r_dcnt;

    logic             r_ovalid;
    logic [OUT_W-1:0] r_odata;

    logic accept;
    logic [31:0] elapsed, in_now, in_elapsed;
    logic [15:0] in_target;
    logic [32:0] half_sum;
    logic signed [33:0] err_now;
    logic signed [34:0] derr, off;
    logic signed [MUL_W-1:0] mul_a, mul_b, factor;
    logic mul_state, mul_load, mul_last, div_last;
    logic signed [PROD_W-1:0] addend, prod_nx, sum72;
    logic [33:0] trial;
    logic        trial_ok;
    logic [DIV_QW-1:0] quo_nx;
    logic sat_hi, sat_lo, p_over;
    logic [15:0] clamp_val;

    localparam logic signed [MUL_W-1:0] ONE30 = MUL_W'(64'h4000_0000);
    localparam logic [PROD_W-1:0] CLAMP_TOP = PROD_W'(64'd32768) << 30;
    localparam logic [PROD_W-1:0] PERIOD_LIM = PROD_W'(MHZ_PER_US);

    assign accept = s_tvalid && s_tready;
    assign s_tready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign m_tvalid = r_ovalid;
    assign m_tdata = r_odata;

    assign in_now = s_tdata[31:0];
    assign in_target = s_tdata[47:32];
    assign in_elapsed = in_now - r_last;
    assign elapsed = r_now - r_last;
    assign half_sum = {1'b0, r_half1} + {1'b0, r_half2};

    assign err_now = $signed({18'b0, r_target}) - $signed({2'b0, r_freq});
    assign derr = {r_err[33], r_err} - {{3{r_prev[31]}}, r_prev};
    assign off = r_prod[34:0];
    assign factor = r_side ? (ONE30 + {{1{off[34]}}, off}) : (ONE30 - {{1{off[34]}}, off});

    assign mul_state = (r_state == S_FF) || (r_state == S_TO) || (r_state == S_PM) ||
                       (r_state == S_DM) || (r_state == S_YW) || (r_state == S_SP);
    assign mul_load = mul_state && !r_busy;
    assign mul_last = mul_state && r_busy && (r_mcnt == MUL_LAST);
    assign div_last = (r_state == S_DIV) && r_busy && (r_dcnt == 5'd0);

    // multiplier step: add, or subtract on the sign bit of the multiplier
    assign addend = r_mplier[0] ? r_mcand : '0;
    assign prod_nx = (r_mcnt == MUL_LAST) ? (r_prod - addend) : (r_prod + addend);

    // restoring divide step
    assign trial = {r_rem, MHZ_PER_US[r_dcnt]};
    assign trial_ok = (trial >= {1'b0, r_dsum});
    assign quo_nx = {r_quo[DIV_QW-2:0], trial_ok};

    // accumulate with saturation to the signed 32 bit range
    assign sum72 = $signed({{(PROD_W-32){r_level[31]}}, r_level}) + (r_acc >>> 16);
    assign sat_hi = !sum72[PROD_W-1] && (|sum72[PROD_W-2:31]);
    assign sat_lo = sum72[PROD_W-1] && !(&sum72[PROD_W-2:31]);

    // clamp of the split product
    assign p_over = !r_prod[PROD_W-1] && (r_prod > CLAMP_TOP);
    always_comb begin
        if (p_over) begin
            clamp_val = FULL_LEVEL;
        end else if (r_prod[PROD_W-1]) begin
            clamp_val = LOW_LEVEL;
        end else begin
            clamp_val = r_prod[45:30];
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_FF: begin
                mul_a = {20'b0, r_target};
                mul_b = {20'b0, r_ffg};
            end
            S_TO: begin
                mul_a = {4'b0, elapsed};
                mul_b = {20'b0, r_target};
            end
            S_PM: begin
                mul_a = {{2{err_now[33]}}, err_now};
                mul_b = {12'b0, r_prop};
            end
            S_DM: begin
                mul_a = {derr[34], derr};
                mul_b = {12'b0, r_deriv};
            end
            S_YW: begin
                mul_a = {20'b0, r_ysg};
                mul_b = {{20{r_yaw[15]}}, r_yaw};
            end
            S_SP: begin
                mul_a = factor;
                mul_b = {{4{r_level[31]}}, r_level};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (s_tuser)
                        KIND_RISE, KIND_FALL: n_state = S_DIV;
                        KIND_UPDATE: begin
                            if (!r_run) begin
                                n_state = S_DONE;
                            end else if (r_half1 == '0 || r_half2 == '0) begin
                                n_state = S_FF;
                            end else if (in_target != '0) begin
                                n_state = S_TO;
                            end else begin
                                n_state = S_PM;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_DIV: begin
                if (!r_busy && half_sum == '0) begin
                    n_state = S_DONE;
                end else if (div_last) begin
                    n_state = S_DONE;
                end
            end
            S_FF:    if (mul_last) n_state = S_YW;
            S_TO:    if (mul_last) n_state = S_TOCHK;
            S_TOCHK: n_state = (r_prod > PERIOD_LIM) ? S_DONE : S_PM;
            S_PM:    if (mul_last) n_state = S_DM;
            S_DM:    if (mul_last) n_state = S_SUM;
            S_SUM:   n_state = S_YW;
            S_YW:    if (mul_last) n_state = S_SP;
            S_SP:    if (mul_last) n_state = S_CLAMP;
            S_CLAMP: n_state = S_DONE;
            S_DONE:  if (!r_ovalid || m_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop <= '0;
            r_deriv <= '0;
            r_ysg <= '0;
            r_ffg <= FF_GAIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_PROP:  r_prop <= i_cfg_data;
                REG_DERIV: r_deriv <= i_cfg_data;
                REG_YAW:   r_ysg <= i_cfg_data[15:0];
                REG_FF:    r_ffg <= i_cfg_data[15:0];
                default:   r_prop <= r_prop;
            endcase
        end
    end

    // event latch, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_now <= in_now;
            r_target <= in_target;
            r_yaw <= s_tdata[63:48];
        end
    end

    // multiplier and divider datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (mul_load) begin
            r_busy <= 1'b1;
        end else if (mul_last || div_last) begin
            r_busy <= 1'b0;
        end else if (r_state == S_DIV && !r_busy && half_sum != '0) begin
            r_busy <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_load) begin
            r_mcand <= {{MUL_W{mul_a[MUL_W-1]}}, mul_a};
            r_mplier <= mul_b;
            r_prod <= '0;
            r_mcnt <= '0;
        end else if (mul_state && r_busy) begin
            r_mcand <= r_mcand <<< 1;
            r_mplier <= r_mplier >> 1;
            r_prod <= prod_nx;
            r_mcnt <= r_mcnt + 6'd1;
        end
        if (r_state == S_DIV) begin
            if (!r_busy) begin
                r_dsum <= half_sum;
                r_rem <= '0;
                r_quo <= '0;
                r_dcnt <= 5'(DIV_QW - 1);
            end else begin
                r_rem <= trial_ok ? 33'(trial - {1'b0, r_dsum}) : trial[32:0];
                r_quo <= quo_nx;
                r_dcnt <= r_dcnt - 5'd1;
            end
        end
        if (r_state == S_PM && mul_load) begin
            r_err <= err_now;
        end
        if (r_state == S_DM && mul_load) begin
            r_acc <= r_prod;
        end
        if (r_state == S_SUM) begin
            r_acc <= r_acc + r_prod;
        end
    end

    // loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= 1'b1;
            r_half1 <= '0;
            r_half2 <= '0;
            r_last <= '0;
            r_freq <= '0;
            r_prev <= '0;
            r_level <= '0;
            r_run <= 1'b0;
            r_pump <= '0;
            r_valve <= '0;
            r_tout <= 1'b0;
            r_pd <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_tout <= 1'b0;
                        case (s_tuser)
                            KIND_RISE: begin
                                r_side <= 1'b1;
                                r_half1 <= in_elapsed;
                                r_last <= in_now;
                            end
                            KIND_FALL: begin
                                r_side <= 1'b0;
                                r_half2 <= in_elapsed;
                                r_last <= in_now;
                            end
                            KIND_UPDATE: begin
                                if (r_run) begin
                                    r_pump <= (s_tdata[79:64] > FULL_LEVEL) ?
                                              FULL_LEVEL : s_tdata[79:64];
                                    r_pd <= !(r_half1 == '0 || r_half2 == '0);
                                end
                            end
                            KIND_START: begin
                                r_valve <= '0;
                                r_pump <= '0;
                                r_half1 <= '0;
                                r_half2 <= '0;
                                r_last <= in_now;
                                r_run <= 1'b1;
                            end
                            KIND_STOP: begin
                                r_pump <= '0;
                                r_valve <= '0;
                                r_level <= '0;
                                r_run <= 1'b0;
                            end
                            default: r_tout <= 1'b0;
                        endcase
                    end
                end
                S_DIV: begin
                    if (!r_busy && half_sum == '0) begin
                        r_freq <= '0;
                    end else if (div_last) begin
                        r_freq <= {2'b0, quo_nx};
                    end
                end
                S_TOCHK: begin
                    if (r_prod > PERIOD_LIM) begin
                        r_pump <= '0;
                        r_valve <= '0;
                        r_level <= '0;
                        r_run <= 1'b0;
                        r_tout <= 1'b1;
                    end
                end
                S_SUM: r_prev <= r_err[31:0];
                S_YW: begin
                    if (mul_load) begin
                        if (!r_pd) begin
                            r_level <= r_prod[43:12];
                        end else if (sat_hi) begin
                            r_level <= 32'sh7FFF_FFFF;
                        end else if (sat_lo) begin
                            r_level <= 32'sh8000_0000;
                        end else begin
                            r_level <= sum72[31:0];
                        end
                    end
                end
                S_CLAMP: r_valve <= clamp_val;
                default: r_tout <= r_tout;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_DONE && (!r_ovalid || m_tready)) begin
            r_ovalid <= 1'b1;
        end else if (m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_ovalid || m_tready)) begin
            r_odata <= {5'b0, r_half2, r_half1, r_freq, r_tout, r_run, r_side,
                        r_valve, r_pump};
        end
    end

endmodule

/* rtl/core/vfpd_chk.sv */
// vfpd_chk: port-level checks for valve_frequency_pd_with_yaw_split
// depends on vfpd_pkg; bound to the top level below
`timescale 1ns / 1ps

module vfpd_chk
    import vfpd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_cfg_valid,
    input logic              o_cfg_ready,
    input logic [1:0]        i_cfg_index,
    input logic [23:0]       i_cfg_data,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [IN_W-1:0]   s_tdata,
    input logic [2:0]        s_tuser,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_W-1:0]  m_tdata
);

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed under stall");

    // one word in flight: ready drops after an accepted word
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready held after accept");

    // a timed out update leaves the loop stopped with zero drive
    a_tout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[34] |-> !m_tdata[33] && m_tdata[31:0] == '0)
        else $error("timeout with loop running");

    // drive levels never exceed full scale
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata[15:0] <= FULL_LEVEL && m_tdata[31:16] <= FULL_LEVEL)
        else $error("drive level above full");

    // reset empties the output
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind valve_frequency_pd_with_yaw_split vfpd_chk u_vfpd_chk (.*);
